// ----- src/buzzer_pattern_sequencer_assert.svh -----
// assertion macros shared by the sequencer modules
`ifndef BUZZER_PATTERN_SEQUENCER_ASSERT_SVH
`define BUZZER_PATTERN_SEQUENCER_ASSERT_SVH

// expression holds at every clock edge out of reset
`define BPS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define BPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/bps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg
// types, constants and helpers for the buzzer pattern sequencer
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DUR_W       = 16;
    localparam int QCOUNT_W    = 4;

    localparam logic [DUR_W-1:0] MIN_TICKS = DUR_W'(2);

    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_ENQUEUE = 1'b1;

    typedef struct packed {
        logic             mode;
        logic             tone_on;
        logic [DUR_W-1:0] duration;
    } item_in_t;

    typedef struct packed {
        logic                accepted;
        logic                buzzer_level;
        logic                busy_res;
        logic [QCOUNT_W-1:0] queue_count;
    } item_out_t;

    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] duration;
    } step_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        step_t            wdata;
    } q_ctl_t;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [CNT_W-1:0] count;
        step_t            head;
    } q_stat_t;

    function automatic logic [DUR_W-1:0] clamp_duration(input logic [DUR_W-1:0] dur);
        return (dur < MIN_TICKS) ? MIN_TICKS : dur;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

endpackage

// ----- src/bps_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_queue
// ring fifo of pending buzzer steps with read/write pointers and fill count
// ----------------------------------------------------------------------------
`include "buzzer_pattern_sequencer_assert.svh"

module bps_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  bps_pkg::q_ctl_t  ctl,
    output bps_pkg::q_stat_t stat
);

    bps_pkg::step_t                  store_reg [bps_pkg::QUEUE_DEPTH];
    logic [bps_pkg::PTR_W-1:0]       rd_ptr_reg;
    logic [bps_pkg::PTR_W-1:0]       rd_ptr_next;
    logic [bps_pkg::PTR_W-1:0]       wr_ptr_reg;
    logic [bps_pkg::PTR_W-1:0]       wr_ptr_next;
    logic [bps_pkg::CNT_W-1:0]       count_reg;
    logic [bps_pkg::CNT_W-1:0]       count_next;

    always_comb begin
        rd_ptr_next = ctl.pop  ? bps_pkg::ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        wr_ptr_next = ctl.push ? bps_pkg::ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        count_next  = count_reg + bps_pkg::CNT_W'(ctl.push) - bps_pkg::CNT_W'(ctl.pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            store_reg[wr_ptr_reg] <= ctl.wdata;
        end
    end

    always_comb begin
        stat.full  = (count_reg == bps_pkg::CNT_W'(bps_pkg::QUEUE_DEPTH));
        stat.empty = (count_reg == '0);
        stat.count = count_reg;
        stat.head  = store_reg[rd_ptr_reg];
    end

    `BPS_ASSERT_ALWAYS(a_count_range, count_reg <= bps_pkg::CNT_W'(bps_pkg::QUEUE_DEPTH), "fifo count beyond depth")
    `BPS_ASSERT_IMPLY(a_no_push_full, ctl.push, !stat.full, "push into full fifo")
    `BPS_ASSERT_IMPLY(a_no_pop_empty, ctl.pop, !stat.empty || ctl.push, "pop from empty fifo")
    `BPS_ASSERT_IMPLY(a_ptr_match, rd_ptr_reg == wr_ptr_reg, stat.empty || stat.full, "pointers disagree with count")

endmodule

// ----- src/bps_player.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_player
// step countdown and buzzer level; decides fifo push/pop for each beat
// ----------------------------------------------------------------------------
`include "buzzer_pattern_sequencer_assert.svh"

module bps_player (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  bps_pkg::item_in_t   item,
    input  bps_pkg::q_stat_t    stat,
    output bps_pkg::q_ctl_t     ctl,
    output bps_pkg::item_out_t  result
);

    logic                       playing_reg;
    logic                       playing_next;
    logic [bps_pkg::DUR_W-1:0]  ticks_reg;
    logic [bps_pkg::DUR_W-1:0]  ticks_next;
    logic                       level_reg;
    logic                       level_next;
    logic [bps_pkg::DUR_W-1:0]  ticks_dec;
    logic [bps_pkg::CNT_W-1:0]  count_next;
    logic                       accepted;

    always_comb begin
        ctl.push       = 1'b0;
        ctl.pop        = 1'b0;
        ctl.wdata      = {item.tone_on, item.duration};
        playing_next   = playing_reg;
        ticks_next     = ticks_reg;
        level_next     = level_reg;
        accepted       = 1'b0;
        ticks_dec      = (ticks_reg != '0) ? ticks_reg - bps_pkg::DUR_W'(1) : ticks_reg;

        if (item_valid) begin
            if (item.mode == bps_pkg::MODE_ENQUEUE) begin
                if (!stat.full) begin
                    ctl.push = 1'b1;
                    accepted = 1'b1;
                    // idle player starts the new step straight from the beat
                    if (!playing_reg) begin
                        ctl.pop      = 1'b1;
                        playing_next = 1'b1;
                        level_next   = item.tone_on;
                        ticks_next   = bps_pkg::clamp_duration(item.duration);
                    end
                end
            end else if (playing_reg) begin
                ticks_next = ticks_dec;
                if (ticks_dec == '0) begin
                    if (!stat.empty) begin
                        ctl.pop      = 1'b1;
                        level_next   = stat.head.level;
                        ticks_next   = bps_pkg::clamp_duration(stat.head.duration);
                    end else begin
                        playing_next = 1'b0;
                    end
                end
            end
        end

        count_next          = stat.count + bps_pkg::CNT_W'(ctl.push)
                              - bps_pkg::CNT_W'(ctl.pop);
        result.accepted     = accepted;
        result.buzzer_level = level_next;
        result.busy_res     = playing_next;
        result.queue_count  = bps_pkg::QCOUNT_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playing_reg <= 1'b0;
            ticks_reg   <= '0;
            level_reg   <= 1'b0;
        end else begin
            playing_reg <= playing_next;
            ticks_reg   <= ticks_next;
            level_reg   <= level_next;
        end
    end

    `BPS_ASSERT_IMPLY(a_playing_ticks, playing_reg, ticks_reg != '0, "playing step with no ticks left")
    `BPS_ASSERT_IMPLY(a_idle_empty, !playing_reg, stat.empty, "steps waiting while idle")

endmodule

// ----- src/buzzer_pattern_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// plays queued buzzer on/off steps, each held for a number of tick beats
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one beat is either a tick (mode 0) or an enqueue of a step
//   (mode 1) carrying the buzzer level and a duration in ticks; durations
//   below 2 are played as 2. enqueues into a full queue are refused.
//   m_ channel: exactly one result beat per input beat, in order, giving
//   whether the enqueue was stored, the buzzer level, the busy flag and
//   the number of steps still waiting.
//   path: an accepted input beat is held in the input register, then its
//   result is written into the result register.
//   throughput: one beat per cycle while m_ready is high; the fifo read, countdown and reload
//   all settle in the single stage between the two registers.
//   reset: queue empty, player idle, buzzer off; no clearing pass, the step
//   store is only read after it is written.
//   stall: when m_ready is low the result register holds, the input
//   register still takes one more beat, then s_ready drops until the
//   result is taken.
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bps_pkg::item_in_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bps_pkg::item_out_t  m_item
);

    logic                in_valid_reg;
    logic                in_valid_next;
    bps_pkg::item_in_t   in_item_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    bps_pkg::item_out_t  out_item_reg;
    logic                advance;
    bps_pkg::q_ctl_t     q_ctl;
    bps_pkg::q_stat_t    q_stat;
    bps_pkg::item_out_t  result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    bps_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (q_ctl),
        .stat    (q_stat)
    );

    bps_player u_player (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .item       (in_item_reg),
        .stat       (q_stat),
        .ctl        (q_ctl),
        .result     (result)
    );

endmodule
